// File: rtl/grc_pkg.sv
// shared types and constants of the gpio register controller
package grc_pkg;

  localparam int MAX_PINS      = 64;
  localparam int OUT_W         = 54;
  localparam int DATA_W        = 32;
  localparam int WORD_W        = 6;
  localparam int MODE_W        = 3;
  localparam int PULL_W        = 2;
  localparam int FSEL_WORDS    = 6;
  localparam int PINS_PER_FSEL = 10;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [WORD_W-1:0] W_FSEL_FIRST = 6'd0;
  localparam logic [WORD_W-1:0] W_FSEL_LAST  = 6'd5;
  localparam logic [WORD_W-1:0] W_SET0       = 6'd7;
  localparam logic [WORD_W-1:0] W_SET1       = 6'd8;
  localparam logic [WORD_W-1:0] W_CLR0       = 6'd10;
  localparam logic [WORD_W-1:0] W_CLR1       = 6'd11;
  localparam logic [WORD_W-1:0] W_LEV0       = 6'd13;
  localparam logic [WORD_W-1:0] W_LEV1       = 6'd14;
  localparam logic [WORD_W-1:0] W_PUD        = 6'd37;
  localparam logic [WORD_W-1:0] W_PUDCLK0    = 6'd38;
  localparam logic [WORD_W-1:0] W_PUDCLK1    = 6'd39;

  localparam logic [MODE_W-1:0] MODE_OUTPUT = 3'd1;
  localparam logic [PULL_W-1:0] PULL_DOWN   = 2'd1;
  localparam logic [PULL_W-1:0] PULL_UP     = 2'd2;

  typedef struct packed {
    logic              opcode;
    logic [WORD_W-1:0] word_index;
    logic [DATA_W-1:0] write_data;
    logic [OUT_W-1:0]  pin_levels;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [OUT_W-1:0]  output_latch;
    logic [OUT_W-1:0]  output_enable;
    logic [OUT_W-1:0]  pull_up_mask;
    logic [OUT_W-1:0]  pull_down_mask;
  } result_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

endpackage

// File: rtl/grc_if.sv
// valid/ready channel interfaces for bus accesses and results
interface grc_in_if
  import grc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [WORD_W-1:0] word_index;
  logic [DATA_W-1:0] write_data;
  logic [OUT_W-1:0]  pin_levels;

  modport source (output valid, opcode, word_index, write_data, pin_levels, input ready);
  modport sink   (input valid, opcode, word_index, write_data, pin_levels, output ready);
endinterface

interface grc_out_if
  import grc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [OUT_W-1:0]  output_latch;
  logic [OUT_W-1:0]  output_enable;
  logic [OUT_W-1:0]  pull_up_mask;
  logic [OUT_W-1:0]  pull_down_mask;

  modport source (output valid, read_data, output_latch, output_enable, pull_up_mask,
                  pull_down_mask, input ready);
  modport sink   (input valid, read_data, output_latch, output_enable, pull_up_mask,
                  pull_down_mask, output ready);
endinterface

// File: rtl/grc_in_stage.sv
// input register holding one bus access ahead of the register bank
module grc_in_stage
  import grc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  grc_in_if.sink in_chan,
  input  logic   advance,
  output stage_t stage
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  take;

  assign in_chan.ready = !valid_r || advance;
  assign take          = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.opcode     <= in_chan.opcode;
      item_r.word_index <= in_chan.word_index;
      item_r.write_data <= in_chan.write_data;
      item_r.pin_levels <= in_chan.pin_levels;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

// File: rtl/grc_regfile.sv
// gpio state registers, access decode and pin mask generation
module grc_regfile
  import grc_pkg::*;
#(
  parameter int NUM_PINS = 54
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    upd_en,
  input  item_t   item,
  output result_t res
);

  localparam int FSEL_FULL_W = MAX_PINS * MODE_W;
  localparam int PULL_FULL_W = MAX_PINS * PULL_W;
  localparam logic [MAX_PINS-1:0] PIN_MASK = {MAX_PINS{1'b1}} >> (MAX_PINS - NUM_PINS);

  logic [NUM_PINS*MODE_W-1:0] fsel_r, fsel_nxt;
  logic [NUM_PINS-1:0]        bits_r, bits_nxt;
  logic [PULL_W-1:0]          pud_r, pud_nxt;
  logic [NUM_PINS*PULL_W-1:0] pst_r, pst_nxt;

  logic [FSEL_FULL_W-1:0] fsel_cur, fsel_new;
  logic [MAX_PINS-1:0]    bits_cur, bits_new;
  logic [PULL_FULL_W-1:0] pst_cur, pst_new;
  logic [MAX_PINS-1:0]    data_sh, data_dup, levels;
  logic [DATA_W-1:0]      rd;
  logic                   wr;

  assign fsel_cur = FSEL_FULL_W'(fsel_r);
  assign bits_cur = MAX_PINS'(bits_r);
  assign pst_cur  = PULL_FULL_W'(pst_r);
  assign levels   = MAX_PINS'(item.pin_levels) & PIN_MASK;
  assign wr       = (item.opcode == OP_WRITE);
  assign data_dup = {item.write_data, item.write_data};
  assign data_sh  = (item.word_index == W_SET0 || item.word_index == W_CLR0) ?
                    {32'b0, item.write_data} : {item.write_data, 32'b0};

  always_comb begin
    fsel_new = fsel_cur;
    bits_new = bits_cur;
    pud_nxt  = pud_r;
    pst_new  = pst_cur;
    rd       = '0;
    if (wr) begin
      case (item.word_index) inside
        [W_FSEL_FIRST:W_FSEL_LAST]: begin
          for (int w = 0; w < FSEL_WORDS; w++) begin
            for (int k = 0; k < PINS_PER_FSEL; k++) begin
              if (item.word_index == WORD_W'(w)) begin
                fsel_new[(w*PINS_PER_FSEL+k)*MODE_W +: MODE_W] =
                  item.write_data[k*MODE_W +: MODE_W];
              end
            end
          end
        end
        W_SET0, W_SET1: begin
          bits_new = bits_cur | data_sh;
        end
        W_CLR0, W_CLR1: begin
          bits_new = bits_cur & ~data_sh;
        end
        W_PUD: begin
          pud_nxt = item.write_data[PULL_W-1:0];
        end
        W_PUDCLK0, W_PUDCLK1: begin
          // pins 0..31 follow the first clock word, the rest the second
          for (int p = 0; p < MAX_PINS; p++) begin
            if (data_dup[p] && (item.word_index == ((p < DATA_W) ? W_PUDCLK0 : W_PUDCLK1))) begin
              pst_new[p*PULL_W +: PULL_W] = pud_r;
            end
          end
        end
        default: begin
        end
      endcase
    end else begin
      case (item.word_index) inside
        [W_FSEL_FIRST:W_FSEL_LAST]: begin
          for (int w = 0; w < FSEL_WORDS; w++) begin
            if (item.word_index == WORD_W'(w)) begin
              for (int k = 0; k < PINS_PER_FSEL; k++) begin
                rd[k*MODE_W +: MODE_W] = fsel_cur[(w*PINS_PER_FSEL+k)*MODE_W +: MODE_W];
              end
            end
          end
        end
        W_LEV0: rd = levels[DATA_W-1:0];
        W_LEV1: rd = levels[MAX_PINS-1:DATA_W];
        W_PUD:  rd = DATA_W'(pud_r);
        default: rd = '0;
      endcase
    end
  end

  assign fsel_nxt = fsel_new[NUM_PINS*MODE_W-1:0];
  assign bits_nxt = bits_new[NUM_PINS-1:0];
  assign pst_nxt  = pst_new[NUM_PINS*PULL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsel_r <= '0;
      bits_r <= '0;
      pud_r  <= '0;
      pst_r  <= '0;
    end else if (upd_en) begin
      fsel_r <= fsel_nxt;
      bits_r <= bits_nxt;
      pud_r  <= pud_nxt;
      pst_r  <= pst_nxt;
    end
  end

  // masks reflect the state after this access, pins past the last one stay clear
  always_comb begin
    res.read_data      = rd;
    res.output_latch   = OUT_W'(bits_nxt);
    res.output_enable  = '0;
    res.pull_up_mask   = '0;
    res.pull_down_mask = '0;
    for (int i = 0; i < OUT_W; i++) begin
      if (i < NUM_PINS) begin
        res.output_enable[i]  = (fsel_new[i*MODE_W +: MODE_W] == MODE_OUTPUT);
        res.pull_up_mask[i]   = (pst_new[i*PULL_W +: PULL_W] == PULL_UP);
        res.pull_down_mask[i] = (pst_new[i*PULL_W +: PULL_W] == PULL_DOWN);
      end
    end
  end

endmodule

// File: rtl/grc_out_stage.sv
// result register driving the output channel
module grc_out_stage
  import grc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  result_t   res,
  output logic      can_load,
  grc_out_if.source out_chan
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign can_load = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_chan.valid          = valid_r;
  assign out_chan.read_data      = res_r.read_data;
  assign out_chan.output_latch   = res_r.output_latch;
  assign out_chan.output_enable  = res_r.output_enable;
  assign out_chan.pull_up_mask   = res_r.pull_up_mask;
  assign out_chan.pull_down_mask = res_r.pull_down_mask;

endmodule

// File: rtl/gpio_register_controller.sv
// gpio register controller top level
// the result passes through the input register and then the result register before it is offered
// throughput: one access per cycle while the result register can take it; the register bank updates
// as an access moves to the result register
// an access can transfer into the input register while a result waits at the output
// reset (synchronous, active low) clears function selects, output latch, pull code and pull states
module gpio_register_controller
  import grc_pkg::*;
#(
  parameter int NUM_PINS = 54
) (
  input  logic      clk,
  input  logic      rst_n,
  grc_in_if.sink    in_chan,
  grc_out_if.source out_chan
);

  stage_t  stage;
  result_t res;
  logic    can_load;
  logic    advance;

  assign advance = stage.valid && can_load;

  grc_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .advance (advance),
    .stage   (stage)
  );

  grc_regfile #(
    .NUM_PINS (NUM_PINS)
  ) u_regfile (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (advance),
    .item   (stage.item),
    .res    (res)
  );

  grc_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (advance),
    .res      (res),
    .can_load (can_load),
    .out_chan (out_chan)
  );

endmodule

// File: rtl/grc_checker.sv
// port-level checks for the gpio register controller
module grc_checker
  import grc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_read_data,
  input logic [OUT_W-1:0]  out_latch,
  input logic [OUT_W-1:0]  out_pu,
  input logic [OUT_W-1:0]  out_pd
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) && $stable(out_latch))
    else $error("result changed while stalled");

  // a pin never pulls both ways
  a_pull_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pu & out_pd) == '0)
    else $error("pull up and pull down overlap");

  // with no result waiting the input side is open
  a_ready_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // a transfer in is passed on to the output when the output can take it
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 (!out_valid || out_ready) |=> out_valid)
    else $error("transferred access produced no result");

endmodule

bind gpio_register_controller grc_checker u_grc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_read_data (out_chan.read_data),
  .out_latch     (out_chan.output_latch),
  .out_pu        (out_chan.pull_up_mask),
  .out_pd        (out_chan.pull_down_mask)
);

// File: test/tb.sv
// testbench for the gpio register controller: directed table, then random bus accesses
module tb;
  import grc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIN_COUNT = 54;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 10;

  localparam logic [WORD_W-1:0] W_FSEL1  = 6'd1;
  localparam logic [WORD_W-1:0] W_UNUSED = 6'd63;

  localparam logic [OUT_W-1:0] ALL_PINS = {OUT_W{1'b1}};

  typedef enum int {IDLE_NONE, IDLE_SOME, IDLE_FULL} idle_mode_t;

  typedef struct packed {
    logic              op;
    logic [WORD_W-1:0] word;
    logic [DATA_W-1:0] data;
    logic [OUT_W-1:0]  levels;
    logic              fixed;
    logic [DATA_W-1:0] rd;
  } step_t;

  // fixed rows carry read data that is plain from the word map
  localparam step_t SCRIPT [26] = '{
    '{OP_READ,  W_FSEL_FIRST, 32'h0,        54'h0,    1'b1, 32'h0},
    '{OP_READ,  W_PUD,        32'hFFFFFFFF, ALL_PINS, 1'b1, 32'h0},
    '{OP_READ,  W_LEV0,       32'h0,        ALL_PINS, 1'b1, 32'hFFFFFFFF},
    '{OP_READ,  W_LEV1,       32'h0,        ALL_PINS, 1'b1, 32'h003FFFFF},
    '{OP_READ,  W_LEV1,       32'h0,        54'h0,    1'b1, 32'h0},
    '{OP_WRITE, W_FSEL_FIRST, 32'hFFFFFFFF, 54'h0,    1'b1, 32'h0},
    '{OP_READ,  W_FSEL_FIRST, 32'h0,        54'h0,    1'b1, 32'h3FFFFFFF},
    '{OP_WRITE, W_FSEL_LAST,  32'h09249249, ALL_PINS, 1'b0, 32'h0},
    '{OP_READ,  W_FSEL_LAST,  32'h0,        54'h0,    1'b1, 32'h00000249},
    '{OP_WRITE, W_FSEL1,      32'h09249249, 54'h0,    1'b0, 32'h0},
    '{OP_WRITE, W_SET0,       32'hFFFFFFFF, 54'h0,    1'b0, 32'h0},
    '{OP_WRITE, W_SET1,       32'hFFFFFFFF, 54'h0,    1'b0, 32'h0},
    '{OP_READ,  W_SET0,       32'h0,        54'h0,    1'b1, 32'h0},
    '{OP_WRITE, W_CLR1,       32'hFFFFFFFF, 54'h0,    1'b0, 32'h0},
    '{OP_WRITE, W_CLR0,       32'hAAAAAAAA, 54'h0,    1'b0, 32'h0},
    '{OP_WRITE, W_LEV0,       32'h12345678, ALL_PINS, 1'b1, 32'h0},
    '{OP_WRITE, W_PUD,        32'hFFFFFFFE, 54'h0,    1'b0, 32'h0},
    '{OP_READ,  W_PUD,        32'h0,        54'h0,    1'b1, 32'h2},
    '{OP_WRITE, W_PUDCLK0,    32'hFFFFFFFF, 54'h0,    1'b0, 32'h0},
    '{OP_WRITE, W_PUD,        32'h00000001, 54'h0,    1'b0, 32'h0},
    '{OP_WRITE, W_PUDCLK1,    32'hFFFFFFFF, 54'h0,    1'b0, 32'h0},
    '{OP_WRITE, W_PUD,        32'h00000003, 54'h0,    1'b0, 32'h0},
    '{OP_WRITE, W_PUDCLK0,    32'h0000FFFF, 54'h0,    1'b0, 32'h0},
    '{OP_READ,  W_PUDCLK1,    32'h0,        54'h0,    1'b1, 32'h0},
    '{OP_WRITE, W_UNUSED,     32'hFFFFFFFF, 54'h0,    1'b0, 32'h0},
    '{OP_READ,  W_UNUSED,     32'h0,        ALL_PINS, 1'b1, 32'h0}
  };

  logic clk;
  logic rst_n;

  grc_in_if  in_chan ();
  grc_out_if out_chan ();

  gpio_register_controller #(
    .NUM_PINS(PIN_COUNT)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // predicted register bank
  logic [MODE_W-1:0] pin_mode [PIN_COUNT];
  logic [OUT_W-1:0]  latch_bits;
  logic [PULL_W-1:0] pull_code;
  logic [PULL_W-1:0] pin_pull [PIN_COUNT];

  result_t    access_results_q [$];
  int         mismatch_count;
  int         cycle_count;
  idle_mode_t idle_mode;
  int         hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatch_count++;
  endtask

  function automatic int draw_idle();
    case (idle_mode)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 19);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
    endcase
  endfunction

  // applies one access to the predicted bank and returns the state after it
  task automatic predict_access(input item_t a, output result_t r);
    logic [63:0] wide;
    logic [63:0] lev;
    int          pin;
    int          half;
    r    = '0;
    lev  = {10'b0, a.pin_levels};
    wide = {10'b0, latch_bits};
    if (a.opcode == OP_WRITE) begin
      if (a.word_index <= W_FSEL_LAST) begin
        for (int k = 0; k < PINS_PER_FSEL; k++) begin
          pin = int'(a.word_index) * PINS_PER_FSEL + k;
          if (pin < PIN_COUNT) pin_mode[pin] = a.write_data[MODE_W*k +: MODE_W];
        end
      end else if (a.word_index == W_SET0 || a.word_index == W_SET1) begin
        wide = wide | ({32'b0, a.write_data} << (32 * int'(a.word_index - W_SET0)));
      end else if (a.word_index == W_CLR0 || a.word_index == W_CLR1) begin
        wide = wide & ~({32'b0, a.write_data} << (32 * int'(a.word_index - W_CLR0)));
      end else if (a.word_index == W_PUD) begin
        pull_code = a.write_data[PULL_W-1:0];
      end else if (a.word_index == W_PUDCLK0 || a.word_index == W_PUDCLK1) begin
        half = int'(a.word_index - W_PUDCLK0);
        for (int b = 0; b < DATA_W; b++) begin
          pin = half * DATA_W + b;
          if (pin < PIN_COUNT && a.write_data[b]) pin_pull[pin] = pull_code;
        end
      end
      latch_bits = wide[OUT_W-1:0];
    end else begin
      if (a.word_index <= W_FSEL_LAST) begin
        for (int k = 0; k < PINS_PER_FSEL; k++) begin
          pin = int'(a.word_index) * PINS_PER_FSEL + k;
          if (pin < PIN_COUNT) r.read_data[MODE_W*k +: MODE_W] = pin_mode[pin];
        end
      end else if (a.word_index == W_LEV0) begin
        r.read_data = lev[31:0];
      end else if (a.word_index == W_LEV1) begin
        r.read_data = lev[63:32];
      end else if (a.word_index == W_PUD) begin
        r.read_data = {30'b0, pull_code};
      end
    end
    r.output_latch = latch_bits;
    for (int i = 0; i < PIN_COUNT; i++) begin
      r.output_enable[i]  = (pin_mode[i] == MODE_OUTPUT);
      r.pull_up_mask[i]   = (pin_pull[i] == PULL_UP);
      r.pull_down_mask[i] = (pin_pull[i] == PULL_DOWN);
    end
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_access(input item_t a, input logic fixed, input logic [DATA_W-1:0] rd);
    int      gap;
    result_t r;
    gap = draw_idle();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.opcode     <= a.opcode;
    in_chan.word_index <= a.word_index;
    in_chan.write_data <= a.write_data;
    in_chan.pin_levels <= a.pin_levels;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    predict_access(a, r);
    if (fixed) r.read_data = rd;
    access_results_q.push_back(r);
    @(negedge clk);
  endtask

  function automatic logic [DATA_W-1:0] random_data();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      2:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic item_t random_access();
    item_t a;
    a.opcode     = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
    a.write_data = random_data();
    a.pin_levels = OUT_W'({$urandom, $urandom});
    case ($urandom_range(0, 9))
      0, 1, 2: a.word_index = WORD_W'($urandom_range(W_FSEL_FIRST, W_FSEL_LAST));
      3:       a.word_index = $urandom_range(0, 1) ? W_SET1 : W_SET0;
      4:       a.word_index = $urandom_range(0, 1) ? W_CLR1 : W_CLR0;
      5:       a.word_index = $urandom_range(0, 1) ? W_LEV1 : W_LEV0;
      6: begin
        a.word_index = W_PUD;
        // mostly a plain pull code, sometimes wide data
        if ($urandom_range(0, 3) != 0) a.write_data = $urandom_range(0, 3);
      end
      7:       a.word_index = $urandom_range(0, 1) ? W_PUDCLK1 : W_PUDCLK0;
      default: a.word_index = WORD_W'($urandom_range(0, 63));
    endcase
    return a;
  endfunction

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) send_access(random_access(), 1'b0, '0);
  endtask

  // result side: stalls per transfer, plus one long hold on request
  initial begin
    int n;
    out_chan.ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else begin
        n = draw_idle();
      end
      if (n > 0) begin
        out_chan.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (access_results_q.size() == 0) begin
        report_mismatch("result with none pending", 64'(out_chan.read_data), '0);
      end else begin
        want = access_results_q.pop_front();
        if (out_chan.read_data !== want.read_data)
          report_mismatch("read_data", 64'(out_chan.read_data), 64'(want.read_data));
        if (out_chan.output_latch !== want.output_latch)
          report_mismatch("output_latch", 64'(out_chan.output_latch),
                          64'(want.output_latch));
        if (out_chan.output_enable !== want.output_enable)
          report_mismatch("output_enable", 64'(out_chan.output_enable),
                          64'(want.output_enable));
        if (out_chan.pull_up_mask !== want.pull_up_mask)
          report_mismatch("pull_up_mask", 64'(out_chan.pull_up_mask),
                          64'(want.pull_up_mask));
        if (out_chan.pull_down_mask !== want.pull_down_mask)
          report_mismatch("pull_down_mask", 64'(out_chan.pull_down_mask),
                          64'(want.pull_down_mask));
      end
    end
  end

  initial begin
    item_t a;
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.opcode     = OP_READ;
    in_chan.word_index = '0;
    in_chan.write_data = '0;
    in_chan.pin_levels = '0;
    mismatch_count     = 0;
    cycle_count        = 0;
    hold_cycles        = 0;
    idle_mode          = IDLE_SOME;
    latch_bits         = '0;
    pull_code          = '0;
    for (int i = 0; i < PIN_COUNT; i++) begin
      pin_mode[i] = '0;
      pin_pull[i] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (SCRIPT[i]) begin
      a.opcode     = SCRIPT[i].op;
      a.word_index = SCRIPT[i].word;
      a.write_data = SCRIPT[i].data;
      a.pin_levels = SCRIPT[i].levels;
      send_access(a, SCRIPT[i].fixed, SCRIPT[i].rd);
    end
    send_random(380);

    // sender waits for the bank to drain before going on
    in_chan.valid <= 1'b0;
    wait (access_results_q.size() == 0);
    @(negedge clk);
    idle_mode = IDLE_FULL;
    send_random(400);

    // back to back with a long receiver hold so the input stalls
    idle_mode   = IDLE_NONE;
    hold_cycles = 300;
    send_random(450);

    in_chan.valid <= 1'b0;
    wait (access_results_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
